>>> hw/rtl/ggm_pkg.sv
// Shared types and constants of the granular grain mixer.
package ggm_pkg;

  localparam int GRAINS = 8;
  localparam int GIDX_W = 3;
  localparam int ADDR_W = 12;
  localparam int DEPTH = 4096;
  localparam int CNT_W = 4;

  typedef enum logic [2:0] {
    CMD_LOAD_SAMPLE = 3'd0,
    CMD_LOAD_WINDOW = 3'd1,
    CMD_PLACE       = 3'd2,
    CMD_NOTE_START  = 3'd3,
    CMD_NOTE_STOP   = 3'd4,
    CMD_TICK        = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    REG_LENGTH   = 2'd0,
    REG_INTERVAL = 2'd1,
    REG_SCATTER  = 2'd2
  } reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PLACE,
    ST_READ,
    ST_ACC,
    ST_DIV,
    ST_TRIG,
    ST_OUT
  } state_t;

endpackage

>>> hw/rtl/ggm_ram.sv
// Generic single-port write, registered-read RAM.
module ggm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/ggm_div.sv
// Restoring divider of a signed 35-bit sum by an unsigned 20-bit divisor, one bit a cycle.
module ggm_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [34:0]  dividend,
  input  logic [19:0]         divisor,
  output logic                busy,
  output logic                done,
  output logic signed [34:0]  quotient
);

  logic [5:0]  cnt_r, cnt_nxt;
  logic [34:0] q_r, q_nxt;
  logic [20:0] rem_r, rem_nxt;
  logic        neg_r, neg_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [19:0] dv_r, dv_nxt;
  logic [20:0] trial;

  // Shift one dividend bit into the partial remainder per cycle.
  always_comb begin
    cnt_nxt = cnt_r;
    q_nxt = q_r;
    rem_nxt = rem_r;
    neg_nxt = neg_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    dv_nxt = dv_r;
    trial = {rem_r[19:0], q_r[34]};
    if (start) begin
      neg_nxt = dividend[34];
      q_nxt = dividend[34] ? 35'(-dividend) : 35'(dividend);
      rem_nxt = '0;
      cnt_nxt = 6'd35;
      busy_nxt = 1'b1;
      dv_nxt = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dv_r}) begin
        rem_nxt = trial - {1'b0, dv_r};
        q_nxt = {q_r[33:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[33:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
    dv_r <= dv_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quotient = neg_r ? -$signed(q_r) : $signed(q_r);

endmodule

>>> hw/rtl/granular_grain_mixer.sv
// Granular grain mixer: top level with the command sequencer and grain bank.
// Usage
//   in_*  : command beats. tdata from bit 0: command[2:0], address[14:3],
//           sample_value[30:15], window_value[46:31], grain_index[49:47],
//           random_value[62:50], zero pad [63].
//   out_* : one beat per tick command. tdata: mix_sample[15:0],
//           active_grains[19:16], zero pad [23:20].
//   cfg_* : register writes, index 0 grain_length, 1 grain_interval,
//           2 scatter; other indexes are dropped.
// Sequence
//   Load, start and stop commands complete in the idle state; a place command
//   passes through the place state (the scatter product is divided by 100
//   through a multiply by the reciprocal). A tick visits the eight grains
//   one after another, a read state for the registered buffer and window
//   reads and an accumulate state for the product, then runs the serial
//   divide in the divide state and then the trigger state. The result beat
//   is offered in the output state, and the next command is taken once it
//   has been accepted; with no active grains the divide is skipped.
// Reset clears grain state, counter and registers; memories are not
// cleared. While the result beat waits for out_tready the block holds it
// and takes no new command.
module granular_grain_mixer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // command, address, sample_value, window_value,
                                  // grain_index, random_value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // mix_sample, active_grains
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import ggm_pkg::*;

  state_t state_r, state_nxt;
  logic [12:0] len_r;
  logic [15:0] intv_r;
  logic [6:0]  scat_r;
  logic [15:0] tick_r;
  logic [ADDR_W-1:0] start_r [GRAINS];
  logic [ADDR_W-1:0] pos_r [GRAINS];
  logic [GRAINS-1:0] act_r;
  logic [2:0]  gi_r;
  logic [12:0] rnd_r;
  logic [19:0] prod_r;
  logic [GIDX_W-1:0] g_r;
  logic signed [34:0] sum_r;
  logic [CNT_W-1:0] cnt_r;
  logic [15:0] mix_r;
  logic signed [31:0] mul;
  logic [15:0] buf_q, win_q;
  logic [ADDR_W-1:0] raddr_b, raddr_w, cur_pos;
  logic [3:0] count_c;
  logic [ADDR_W:0] nextp;
  logic signed [34:0] quot;
  logic div_start, div_busy, div_done;
  logic [33:0] recip;
  logic [13:0] st;
  logic [GIDX_W-1:0] found;
  logic found_ok;
  logic accept;

  wire [2:0]  f_cmd = in_tdata[2:0];
  wire [11:0] f_addr = in_tdata[14:3];
  wire [15:0] f_smp = in_tdata[30:15];
  wire [15:0] f_win = in_tdata[46:31];

  assign accept = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;

  // Grain buffer and window table.
  ggm_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_buf (
    .clk(clk), .we(accept && f_cmd == CMD_LOAD_SAMPLE), .waddr(f_addr),
    .wdata(f_smp), .raddr(raddr_b), .rdata(buf_q));
  ggm_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_win (
    .clk(clk), .we(accept && f_cmd == CMD_LOAD_WINDOW), .waddr(f_addr),
    .wdata(f_win), .raddr(raddr_w), .rdata(win_q));

  assign cur_pos = pos_r[g_r];
  assign raddr_w = cur_pos;
  assign raddr_b = start_r[g_r] + cur_pos;
  assign nextp = {1'b0, cur_pos} + 13'd1;

  // Multiplier for the sample times window product of a tick.
  assign mul = $signed(buf_q) * $signed({1'b0, win_q});

  // floor(x/100) for x below 2^20: the reciprocal is rounded down, so the
  // estimate is never high and at most one step low.
  assign recip = 34'(prod_r) * 34'd10485 >> 20;
  always_comb begin
    logic [19:0] qv;
    logic [19:0] rm;
    qv = 20'(recip);
    rm = prod_r - 20'(qv * 20'd100);
    if (rm >= 20'd100) begin
      qv = qv + 20'd1;
    end
    st = (scat_r == 7'd0) ? 14'd0 : 14'(qv);
  end

  // Active count and first idle grain.
  always_comb begin
    count_c = '0;
    found = '0;
    found_ok = 1'b0;
    for (int i = GRAINS - 1; i >= 0; i--) begin
      if (!act_r[i]) begin
        found = GIDX_W'(i);
        found_ok = 1'b1;
      end
    end
    for (int i = 0; i < GRAINS; i++) begin
      count_c = count_c + 4'(act_r[i]);
    end
  end

  // The divide starts once the whole sum has been gathered.
  assign div_start = (state_r == ST_DIV) && !div_busy && !div_done;

  ggm_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(sum_r),
    .divisor({cnt_r, 16'd0}), .busy(div_busy), .done(div_done), .quotient(quot));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (f_cmd == CMD_TICK) state_nxt = ST_READ;
          else if (f_cmd == CMD_PLACE) state_nxt = ST_PLACE;
        end
      end
      ST_PLACE: state_nxt = ST_IDLE;
      ST_READ:  state_nxt = ST_ACC;
      ST_ACC: begin
        if (g_r == GIDX_W'(GRAINS - 1)) state_nxt = (cnt_r != '0) ? ST_DIV : ST_TRIG;
        else state_nxt = ST_READ;
      end
      ST_DIV:  if (div_done) state_nxt = ST_TRIG;
      ST_TRIG: state_nxt = ST_OUT;
      ST_OUT:  if (out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  // Datapath and grain state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= 13'd1024;
      intv_r <= 16'd1024;
      scat_r <= '0;
      tick_r <= '0;
      act_r <= '0;
      for (int i = 0; i < GRAINS; i++) begin
        start_r[i] <= '0;
        pos_r[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_LENGTH:   len_r <= cfg_data[12:0];
          REG_INTERVAL: intv_r <= cfg_data;
          REG_SCATTER:  scat_r <= cfg_data[6:0];
          default: ;
        endcase
      end
      if (accept && f_cmd == CMD_NOTE_START) begin
        act_r[0] <= 1'b1;
        pos_r[0] <= '0;
      end
      if (accept && f_cmd == CMD_NOTE_STOP) begin
        act_r <= '0;
        for (int i = 0; i < GRAINS; i++) pos_r[i] <= '0;
      end
      if (state_r == ST_PLACE) begin
        if (st + 14'(len_r) >= 14'(DEPTH)) start_r[gi_r] <= ADDR_W'(st + 14'(len_r));
        else start_r[gi_r] <= ADDR_W'(st);
      end
      if (state_r == ST_ACC && act_r[g_r]) begin
        if (nextp >= 13'(len_r) || nextp[ADDR_W]) begin
          act_r[g_r] <= 1'b0;
          pos_r[g_r] <= '0;
        end else begin
          pos_r[g_r] <= nextp[ADDR_W-1:0];
        end
      end
      if (state_r == ST_TRIG) begin
        if (tick_r >= intv_r) begin
          if (found_ok) begin
            act_r[(scat_r != '0) ? GIDX_W'(found + rnd_r[GIDX_W-1:0]) : found] <= 1'b1;
            pos_r[(scat_r != '0) ? GIDX_W'(found + rnd_r[GIDX_W-1:0]) : found] <= '0;
          end
          tick_r <= 16'd1;
        end else begin
          tick_r <= tick_r + 16'd1;
        end
      end
    end
  end

  // Per-item working registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      gi_r <= in_tdata[49:47];
      rnd_r <= in_tdata[62:50];
      prod_r <= 20'(scat_r) * 20'(in_tdata[62:50]);
      g_r <= '0;
      sum_r <= '0;
      cnt_r <= count_c;
      mix_r <= '0;
    end
    if (state_r == ST_ACC) begin
      if (act_r[g_r]) sum_r <= sum_r + 35'(mul);
      g_r <= g_r + GIDX_W'(1);
    end
    if (div_done) begin
      if (quot > 35'sd32767) mix_r <= 16'h7fff;
      else if (quot < -35'sd32768) mix_r <= 16'h8000;
      else mix_r <= quot[15:0];
    end
  end

  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata = {4'd0, cnt_r, mix_r};

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped under stall");
  a_div_tick: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV) else $error("divide finished outside tick");
`endif

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the granular grain mixer: directed table, then random commands.
`default_nettype none
module tb_top;
  import ggm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         CYCLE_LIMIT   = 2000000;
  localparam int         DRAIN_CYCLES  = 200;
  localparam int         LONG_HOLD     = 400;
  localparam logic [2:0] CMD_UNDEF_LO  = 3'd6;
  localparam logic [2:0] CMD_UNDEF_HI  = 3'd7;
  localparam logic [1:0] REG_NONE      = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  granular_grain_mixer DUT (.*);

  always #5 clk = ~clk;

  // One expected tick result.
  typedef struct {
    logic signed [15:0] mix;
    logic [3:0]         count;
  } mix_result_t;

  mix_result_t mix_expect_q[$];
  int          mismatches = 0;
  int          cycles = 0;
  int          beats_sent = 0;
  bit          gaps_on = 1'b0;
  bit          stalls_on = 1'b0;
  bit          hold_req = 1'b0;

  // Predictor state of the grain bank.
  logic signed [15:0] buf_mem [DEPTH];
  logic [15:0]        win_mem [DEPTH];
  bit                 buf_seen [DEPTH];
  bit                 win_seen [DEPTH];
  logic [11:0]        g_start [GRAINS];
  logic [11:0]        g_pos [GRAINS];
  bit                 g_on [GRAINS];
  logic [15:0]        tick_cnt;
  logic [12:0]        len_r;
  logic [15:0]        ival_r;
  logic [6:0]         scat_r;

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** granular_grain_mixer: FAILED **");
      $finish;
    end
  end

  // Check every accepted result beat against the oldest expectation.
  always @(posedge clk) begin
    mix_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (mix_expect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", out_tdata);
      end else begin
        e = mix_expect_q.pop_front();
        if (out_tdata[15:0] !== e.mix || out_tdata[19:16] !== e.count
            || out_tdata[23:20] !== 4'd0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected mix %0d count %0d, got mix %0d count %0d",
                     e.mix, e.count, $signed(out_tdata[15:0]), out_tdata[19:16]);
        end
      end
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_tready <= 1'b1;
        hold_req = 1'b0;
      end else if (stalls_on && $urandom_range(0, 9) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Grain start for a place command.
  function automatic logic [11:0] grain_start_for(logic [12:0] rnd);
    longint st;
    st = 0;
    if (scat_r != 0) st = (longint'(scat_r) * rnd) / 100;
    if (st + len_r >= DEPTH) st = st + len_r - DEPTH;
    return 12'(st % DEPTH);
  endfunction

  // Mix one tick, advance the grains and run the trigger.
  function automatic mix_result_t mix_tick(logic [12:0] rnd);
    mix_result_t r;
    longint      total, mix;
    int          n, next, found;
    logic [11:0] a;
    total = 0;
    n = 0;
    found = -1;
    for (int i = 0; i < GRAINS; i++) if (g_on[i]) n++;
    for (int i = 0; i < GRAINS; i++) begin
      if (g_on[i]) begin
        a = g_start[i] + g_pos[i];
        total += longint'(buf_mem[a]) * longint'(win_mem[g_pos[i]]);
        next = int'(g_pos[i]) + 1;
        if (next >= len_r || next >= DEPTH) begin
          g_on[i] = 1'b0;
          g_pos[i] = '0;
        end else begin
          g_pos[i] = 12'(next);
        end
      end
    end
    mix = 0;
    if (n != 0) begin
      mix = total / (longint'(n) * 65536);
      if (mix > 32767) mix = 32767;
      if (mix < -32768) mix = -32768;
    end
    if (tick_cnt >= ival_r) begin
      for (int i = GRAINS - 1; i >= 0; i--) if (!g_on[i]) found = i;
      if (found >= 0) begin
        if (scat_r > 0) found = (found + rnd) % GRAINS;
        g_on[found] = 1'b1;
        g_pos[found] = '0;
      end
      tick_cnt = '0;
    end
    tick_cnt = tick_cnt + 16'd1;
    r.mix = mix[15:0];
    r.count = (n > 15) ? 4'd15 : n[3:0];
    return r;
  endfunction

  // Drive one command beat; a tick queues either the typed or the predicted result.
  task automatic send_cmd(logic [2:0] cmd, logic [11:0] addr, logic [15:0] smp,
                          logic [15:0] win, logic [2:0] gidx, logic [12:0] rnd,
                          bit typed = 1'b0, mix_result_t typed_res = '{0, 0});
    mix_result_t r;
    case (cmd)
      CMD_LOAD_SAMPLE: begin buf_mem[addr] = smp; buf_seen[addr] = 1'b1; end
      CMD_LOAD_WINDOW: begin win_mem[addr] = win; win_seen[addr] = 1'b1; end
      CMD_PLACE:       g_start[gidx] = grain_start_for(rnd);
      CMD_NOTE_START:  begin g_on[0] = 1'b1; g_pos[0] = '0; end
      CMD_NOTE_STOP:   for (int i = 0; i < GRAINS; i++) begin g_on[i] = 0; g_pos[i] = '0; end
      CMD_TICK: begin
        r = mix_tick(rnd);
        mix_expect_q = {mix_expect_q, (typed ? typed_res : r)};
      end
      default: ;
    endcase
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, rnd, gidx, win, smp, addr, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    beats_sent++;
  endtask

  // Before a tick, load every entry that the active grains are about to read.
  task automatic tick_with_loads(logic [12:0] rnd);
    logic [11:0] a;
    for (int i = 0; i < GRAINS; i++) begin
      if (g_on[i]) begin
        a = g_start[i] + g_pos[i];
        if (!buf_seen[a])
          send_cmd(CMD_LOAD_SAMPLE, a, $urandom, $urandom, $urandom, $urandom);
        if (!win_seen[g_pos[i]])
          send_cmd(CMD_LOAD_WINDOW, g_pos[i], $urandom, $urandom, $urandom, $urandom);
      end
    end
    send_cmd(CMD_TICK, $urandom, $urandom, $urandom, $urandom, rnd);
  endtask

  // Wait for all results, then let any result-free command finish.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (mix_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    case (idx)
      REG_LENGTH:   len_r = val[12:0];
      REG_INTERVAL: ival_r = val;
      REG_SCATTER:  scat_r = val[6:0];
      default: ;
    endcase
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Directed stimulus; typed rows carry a result read straight off the arithmetic.
  typedef struct {
    logic [2:0]  cmd;
    logic [11:0] addr;
    logic [15:0] smp;
    logic [15:0] win;
    logic [2:0]  gidx;
    logic [12:0] rnd;
    bit          typed;
    logic [15:0] mix;
    logic [3:0]  count;
  } stim_row_t;

  stim_row_t directed[] = '{
    '{CMD_TICK,        0,     0,     0,     0, 0,    1, 0,      0},
    '{CMD_LOAD_SAMPLE, 0,     16'h7FFF, 0,  0, 0,    0, 0,      0},
    '{CMD_LOAD_WINDOW, 0,     0,     16'hFFFF, 0, 0, 0, 0,      0},
    '{CMD_LOAD_SAMPLE, 1,     16'h8000, 0,  0, 0,    0, 0,      0},
    '{CMD_LOAD_WINDOW, 1,     0,     16'hFFFF, 0, 0, 0, 0,      0},
    '{CMD_LOAD_SAMPLE, 4095,  16'h8000, 0,  0, 0,    0, 0,      0},
    '{CMD_LOAD_WINDOW, 4095,  0,     0,     0, 0,    0, 0,      0},
    '{CMD_PLACE,       0,     0,     0,     7, 8191, 0, 0,      0},
    '{CMD_PLACE,       0,     0,     0,     0, 0,    0, 0,      0},
    '{CMD_NOTE_START,  0,     0,     0,     0, 0,    0, 0,      0},
    '{CMD_TICK,        0,     0,     0,     0, 0,    1, 32766,  1},
    '{CMD_TICK,        0,     0,     0,     0, 8191, 1, -32767, 1},
    '{CMD_UNDEF_LO,    12'hFFF, 16'hFFFF, 16'hFFFF, 7, 8191, 0, 0, 0},
    '{CMD_UNDEF_HI,    0,     0,     0,     0, 0,    0, 0,      0},
    '{CMD_NOTE_STOP,   0,     0,     0,     0, 0,    0, 0,      0},
    '{CMD_TICK,        0,     0,     0,     0, 0,    1, 0,      0},
    '{CMD_NOTE_START,  0,     0,     0,     0, 0,    0, 0,      0},
    '{CMD_TICK,        0,     0,     0,     0, 4096, 0, 0,      0},
    '{CMD_NOTE_STOP,   0,     0,     0,     0, 0,    0, 0,      0}
  };

  // Register settings per phase: length, interval, scatter.
  logic [15:0] phase_len[]  = '{16, 1,   4096, 0,  8191,  64, 2,  300};
  logic [15:0] phase_ival[] = '{20, 1,   0,    3,  65535, 7,  0,  40};
  logic [15:0] phase_scat[] = '{0,  100, 1,    50, 100,   37, 99, 0};

  initial begin
    int items, per_phase, pick, phase_base;
    bit held, paused;
    mix_result_t tr;
    for (int i = 0; i < GRAINS; i++) begin g_start[i] = '0; g_pos[i] = '0; g_on[i] = 0; end
    for (int i = 0; i < DEPTH; i++) begin buf_seen[i] = 0; win_seen[i] = 0; end
    tick_cnt = '0;
    len_r = 13'd1024;
    ival_r = 16'd1024;
    scat_r = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[k]) begin
      tr.mix = directed[k].mix;
      tr.count = directed[k].count;
      send_cmd(directed[k].cmd, directed[k].addr, directed[k].smp, directed[k].win,
               directed[k].gidx, directed[k].rnd, directed[k].typed, tr);
    end
    drain();
    // An out-of-range register index must leave everything alone.
    write_reg(REG_NONE, 16'hFFFF);

    // Every beat counts towards the total, the loads in front of ticks included.
    per_phase = (1550 - directed.size()) / phase_len.size();
    foreach (phase_len[p]) begin
      write_reg(REG_LENGTH, phase_len[p]);
      write_reg(REG_INTERVAL, phase_ival[p]);
      write_reg(REG_SCATTER, phase_scat[p]);
      gaps_on = (p != phase_len.size() - 1) && (p % 3 != 1);
      stalls_on = (p != phase_len.size() - 1) && (p % 3 != 2);
      phase_base = beats_sent;
      held = 1'b0;
      paused = 1'b0;
      while (beats_sent - phase_base < per_phase) begin
        items = beats_sent - phase_base;
        // Mid-run pressure: hold the result side while ticks keep coming.
        if (p == 2 && !held && items >= per_phase / 2) begin
          hold_req = 1'b1;
          held = 1'b1;
        end
        // And once, let the sender wait until nothing is outstanding.
        if (p == 3 && !paused && items >= per_phase / 2) begin
          paused = 1'b1;
          in_tvalid <= 1'b0;
          @(posedge clk);
          while (mix_expect_q.size() != 0) @(posedge clk);
        end
        pick = $urandom_range(0, 99);
        if (pick < 58) tick_with_loads($urandom);
        else if (pick < 68) send_cmd(CMD_PLACE, $urandom, $urandom, $urandom, $urandom, $urandom);
        else if (pick < 76) send_cmd(CMD_NOTE_START, $urandom, $urandom, $urandom, $urandom, $urandom);
        else if (pick < 79) send_cmd(CMD_NOTE_STOP, $urandom, $urandom, $urandom, $urandom, $urandom);
        else if (pick < 87) send_cmd(CMD_LOAD_SAMPLE, $urandom, $urandom, $urandom, $urandom, $urandom);
        else if (pick < 95) send_cmd(CMD_LOAD_WINDOW, $urandom, $urandom, $urandom, $urandom, $urandom);
        else begin
          send_cmd(($urandom_range(0, 1) != 0) ? CMD_UNDEF_HI : CMD_UNDEF_LO,
                   $urandom, $urandom, $urandom, $urandom, $urandom);
        end
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("** granular_grain_mixer: PASSED **");
    end else begin
      $display("** granular_grain_mixer: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire
